// ----- rtl/core/mdm_pkg.sv -----
// Shared types and constants of the mecanum drive mixer.
package mdm_pkg;

	localparam int unsigned NUM_AXES   = 3;
	localparam int unsigned NUM_WHEELS = 4;
	localparam int unsigned MAG_W      = 7;
	localparam int unsigned WHEEL_W    = 9;
	localparam int unsigned QUOT_W     = 7;
	localparam int unsigned DIVD_W     = 15;

	localparam logic [MAG_W-1:0] FULL_SCALE = 7'd100;

	// floor(n / 10000) equals (n * CUBE_RECIP) >> CUBE_SHIFT for every cube up to 100^3.
	localparam int unsigned  CUBE_SHIFT = 34;
	localparam logic [20:0]  CUBE_RECIP = 21'd1717987;

	typedef enum logic [1:0] {
		REG_DEADBAND     = 2'd0,
		REG_CUBIC_DRIVE  = 2'd1,
		REG_CUBIC_STRAFE = 2'd2,
		REG_CUBIC_TWIST  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [7:0] drive_cmd;
		logic signed [7:0] strafe_cmd;
		logic signed [7:0] twist_cmd;
	} cmd_t;

	typedef struct packed {
		logic signed [7:0] front_left_power;
		logic signed [7:0] front_right_power;
		logic signed [7:0] back_left_power;
		logic signed [7:0] back_right_power;
	} pwr_t;

	// Bit 0 of cubic_en is drive, bit 1 strafe, bit 2 twist.
	typedef struct packed {
		logic [MAG_W-1:0]    deadband;
		logic [NUM_AXES-1:0] cubic_en;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] drive;
		logic signed [7:0] strafe;
		logic signed [7:0] twist;
	} axes_t;

	typedef struct packed {
		logic [NUM_WHEELS-1:0][WHEEL_W-1:0] mag;
		logic [NUM_WHEELS-1:0]              neg;
		logic [WHEEL_W-1:0]                 peak;
	} wheels_t;

endpackage

// ----- rtl/core/mdm_shaper.sv -----
// Axis conditioning pipeline: saturation, deadband and optional cubic shaping.
module mdm_shaper (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  mdm_pkg::cmd_t  cmd,
	input  mdm_pkg::cfg_t  cfg,
	output logic           out_valid,
	output mdm_pkg::axes_t axes
);

	localparam int unsigned NA = mdm_pkg::NUM_AXES;
	localparam int unsigned MW = mdm_pkg::MAG_W;

	logic signed [7:0] raw [NA];
	logic [7:0]        abs_c [NA];
	logic [MW-1:0]     mag_c [NA];
	logic              neg_c [NA];

	logic [MW-1:0] mag_s1 [NA];
	logic          neg_s1 [NA];
	logic [MW-1:0] mag_s2 [NA];
	logic          neg_s2 [NA];
	logic [13:0]   sq_s2 [NA];
	logic [MW-1:0] mag_s3 [NA];
	logic          neg_s3 [NA];
	logic [19:0]   cube_s3 [NA];
	logic [40:0]   prod_c [NA];
	logic [MW-1:0] val_c [NA];
	logic signed [7:0] axis_c [NA];
	mdm_pkg::axes_t axes_s4;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign raw[0] = cmd.drive_cmd;
	assign raw[1] = cmd.strafe_cmd;
	assign raw[2] = cmd.twist_cmd;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			abs_c[i] = raw[i][7] ? 8'(-raw[i]) : 8'(raw[i]);
			if (raw[i] > 8'sd100) begin
				mag_c[i] = mdm_pkg::FULL_SCALE;
				neg_c[i] = 1'b0;
			end else if (raw[i] < -8'sd100) begin
				mag_c[i] = mdm_pkg::FULL_SCALE;
				neg_c[i] = 1'b1;
			end else begin
				mag_c[i] = abs_c[i][MW-1:0];
				neg_c[i] = raw[i][7];
			end
			if (mag_c[i] <= cfg.deadband) begin
				mag_c[i] = '0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			prod_c[i] = 41'(cube_s3[i]) * 41'(mdm_pkg::CUBE_RECIP);
			val_c[i]  = cfg.cubic_en[i] ? prod_c[i][mdm_pkg::CUBE_SHIFT +: MW] : mag_s3[i];
			axis_c[i] = neg_s3[i] ? -$signed({1'b0, val_c[i]}) : $signed({1'b0, val_c[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				mag_s1[i]  <= mag_c[i];
				neg_s1[i]  <= neg_c[i];
				mag_s2[i]  <= mag_s1[i];
				neg_s2[i]  <= neg_s1[i];
				sq_s2[i]   <= 14'(mag_s1[i]) * 14'(mag_s1[i]);
				mag_s3[i]  <= mag_s2[i];
				neg_s3[i]  <= neg_s2[i];
				cube_s3[i] <= 20'(sq_s2[i]) * 20'(mag_s2[i]);
			end
			axes_s4.drive  <= axis_c[0];
			axes_s4.strafe <= axis_c[1];
			axes_s4.twist  <= axis_c[2];
		end
	end

	assign out_valid = valid_s4;
	assign axes      = axes_s4;

endmodule

// ----- rtl/core/mdm_mixer.sv -----
// Wheel mixing pipeline: four wheel sums, their magnitudes and the largest one.
module mdm_mixer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  mdm_pkg::axes_t   axes,
	output logic             out_valid,
	output mdm_pkg::wheels_t wheels
);

	localparam int unsigned NW = mdm_pkg::NUM_WHEELS;
	localparam int unsigned WW = mdm_pkg::WHEEL_W;

	logic signed [9:0] d_c, s_c, t_c;
	logic signed [9:0] p_s5 [NW];
	logic [9:0]        abs_c [NW];
	logic [WW-1:0]     max01_c, max23_c;
	mdm_pkg::wheels_t  wheels_c;
	mdm_pkg::wheels_t  wheels_s6;
	logic              valid_s5, valid_s6;

	assign d_c = 10'(axes.drive);
	assign s_c = 10'(axes.strafe);
	assign t_c = 10'(axes.twist);

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			abs_c[i]           = p_s5[i][9] ? 10'(-p_s5[i]) : 10'(p_s5[i]);
			wheels_c.mag[i]    = abs_c[i][WW-1:0];
			wheels_c.neg[i]    = p_s5[i][9];
		end
		max01_c = (wheels_c.mag[0] > wheels_c.mag[1]) ? wheels_c.mag[0] : wheels_c.mag[1];
		max23_c = (wheels_c.mag[2] > wheels_c.mag[3]) ? wheels_c.mag[2] : wheels_c.mag[3];
		wheels_c.peak = (max01_c > max23_c) ? max01_c : max23_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5[0]   <= d_c + t_c + s_c;
			p_s5[1]   <= d_c - t_c - s_c;
			p_s5[2]   <= d_c + t_c - s_c;
			p_s5[3]   <= d_c - t_c + s_c;
			wheels_s6 <= wheels_c;
		end
	end

	assign out_valid = valid_s6;
	assign wheels    = wheels_s6;

endmodule

// ----- rtl/core/mdm_scaler.sv -----
// Normalising pipeline: restoring division of each wheel power by the peak, one bit a stage.
module mdm_scaler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  mdm_pkg::wheels_t wheels,
	output logic             out_valid,
	output mdm_pkg::pwr_t    pwr
);

	localparam int unsigned NW = mdm_pkg::NUM_WHEELS;
	localparam int unsigned WW = mdm_pkg::WHEEL_W;
	localparam int unsigned MW = mdm_pkg::MAG_W;
	localparam int unsigned QW = mdm_pkg::QUOT_W;
	localparam int unsigned DW = mdm_pkg::DIVD_W;

	logic [DW-1:0]   rem_s   [QW+1][NW];
	logic [QW-1:0]   quot_s  [QW+1][NW];
	logic [MW-1:0]   mag_s   [QW+1][NW];
	logic [NW-1:0]   neg_s   [QW+1];
	logic [WW-1:0]   peak_s  [QW+1];
	logic            need_s  [QW+1];
	logic            valid_s [QW+1];

	logic [MW-1:0]     val_c [NW];
	logic signed [7:0] pw_c  [NW];
	mdm_pkg::pwr_t     pwr_q;
	logic              valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				rem_s[0][i]  <= DW'(wheels.mag[i]) * DW'(mdm_pkg::FULL_SCALE);
				quot_s[0][i] <= '0;
				mag_s[0][i]  <= wheels.mag[i][MW-1:0];
			end
			neg_s[0]  <= wheels.neg;
			peak_s[0] <= wheels.peak;
			need_s[0] <= wheels.peak > WW'(mdm_pkg::FULL_SCALE);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int unsigned BIT = QW - 1 - j;

		logic [DW-1:0] sub_c [NW];
		logic          ge_c  [NW];

		always_comb begin
			for (int i = 0; i < NW; i++) begin
				sub_c[i] = DW'(peak_s[j]) << BIT;
				ge_c[i]  = rem_s[j][i] >= sub_c[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NW; i++) begin
					rem_s[j+1][i]  <= ge_c[i] ? rem_s[j][i] - sub_c[i] : rem_s[j][i];
					quot_s[j+1][i] <= quot_s[j][i] | (QW'(ge_c[i]) << BIT);
					mag_s[j+1][i]  <= mag_s[j][i];
				end
				neg_s[j+1]  <= neg_s[j];
				peak_s[j+1] <= peak_s[j];
				need_s[j+1] <= need_s[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			val_c[i] = need_s[QW] ? quot_s[QW][i] : mag_s[QW][i];
			pw_c[i]  = neg_s[QW][i] ? -$signed({1'b0, val_c[i]}) : $signed({1'b0, val_c[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pwr_q.front_left_power  <= pw_c[0];
			pwr_q.front_right_power <= pw_c[1];
			pwr_q.back_left_power   <= pw_c[2];
			pwr_q.back_right_power  <= pw_c[3];
		end
	end

	assign out_valid = valid_q;
	assign pwr       = pwr_q;

`ifndef SYNTHESIS
	a_peak_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (wheels.mag[0] <= wheels.peak) && (wheels.mag[1] <= wheels.peak) &&
			(wheels.mag[2] <= wheels.peak) && (wheels.mag[3] <= wheels.peak))
		else $error("wheel magnitude above the reported peak");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[QW] && need_s[QW]) |->
			(rem_s[QW][0] < DW'(peak_s[QW])) && (rem_s[QW][1] < DW'(peak_s[QW])) &&
			(rem_s[QW][2] < DW'(peak_s[QW])) && (rem_s[QW][3] < DW'(peak_s[QW])))
		else $error("division remainder not below the divisor");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(pwr.front_left_power  >= -8'sd100) && (pwr.front_left_power  <= 8'sd100) &&
			(pwr.front_right_power >= -8'sd100) && (pwr.front_right_power <= 8'sd100) &&
			(pwr.back_left_power   >= -8'sd100) && (pwr.back_left_power   <= 8'sd100) &&
			(pwr.back_right_power  >= -8'sd100) && (pwr.back_right_power  <= 8'sd100))
		else $error("wheel power outside full scale");
`endif

endmodule

// ----- rtl/core/mecanum_drive_mixer.sv -----
// Top level of the mecanum drive mixer: configuration registers and pipeline.
//
// A command item (drive, strafe and twist in percent) enters on cmd when cmd_valid
// is high and cmd_stall is low. Each axis is saturated to full scale, zeroed
// inside the deadband and optionally shaped by a cubic curve; the four wheel
// powers are mixed and, if any exceeds full scale, all are scaled down by the
// largest magnitude. One power item leaves on pwr for every command item.
// From acceptance to pwr_valid an item passes four stages of axis
// shaping (saturate, square, cube, reciprocal multiply), two of mixing and
// peak search, one to form the dividends, seven of bit-serial division (one
// quotient bit per stage) and the output register.
// Throughput is one item per cycle but for stalls: while pwr_valid and pwr_stall are
// high the whole pipeline holds and cmd_stall is raised; no item is lost.
// Configuration writes on the cfg channel are always taken (cfg_ready is
// constantly high) and should only be made while no item is in flight.
// Reset empties the pipeline and sets the deadband to 5 with cubic shaping off.
module mecanum_drive_mixer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  mdm_pkg::cmd_t cmd,
	output logic          pwr_valid,
	input  logic          pwr_stall,
	output mdm_pkg::pwr_t pwr,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [6:0]    cfg_data
);

	mdm_pkg::cfg_t    cfg_q;
	mdm_pkg::axes_t   axes;
	mdm_pkg::wheels_t wheels;
	logic             en;
	logic             axes_valid;
	logic             wheels_valid;

	assign en        = !(pwr_valid && pwr_stall);
	assign cmd_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband <= 7'd5;
			cfg_q.cubic_en <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mdm_pkg::REG_DEADBAND: begin
					cfg_q.deadband <= cfg_data;
				end
				mdm_pkg::REG_CUBIC_DRIVE: begin
					cfg_q.cubic_en[0] <= cfg_data[0];
				end
				mdm_pkg::REG_CUBIC_STRAFE: begin
					cfg_q.cubic_en[1] <= cfg_data[0];
				end
				mdm_pkg::REG_CUBIC_TWIST: begin
					cfg_q.cubic_en[2] <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	mdm_shaper u_shaper (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cmd_valid),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.out_valid (axes_valid),
		.axes      (axes)
	);

	mdm_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (axes_valid),
		.axes      (axes),
		.out_valid (wheels_valid),
		.wheels    (wheels)
	);

	mdm_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (wheels_valid),
		.wheels    (wheels),
		.out_valid (pwr_valid),
		.pwr       (pwr)
	);

endmodule
